[hw/rtl/nmea_rmc_position_extractor_core_assert.svh]
// assertion macros shared by the position extractor rtl
// no dependencies; included by the files that carry assertions
`ifndef NMEA_RMC_POSITION_EXTRACTOR_CORE_ASSERT_SVH
`define NMEA_RMC_POSITION_EXTRACTOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define NRPE_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define NRPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define NRPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NRPE_ASSERT(lbl, clk, rst_n, expr)
`define NRPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define NRPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/nrpe_pkg.sv]
// types, character codes and small tables of the rmc position extractor
// no dependencies
package nrpe_pkg;

    localparam int VAL_W    = 30;
    localparam int OUT_W    = 31;
    localparam int POW_W    = 20;
    localparam int PROD_W   = VAL_W + POW_W;
    localparam int HDR_LEN  = 6;

    localparam logic [VAL_W-1:0] SAT_MAG = 30'd999999999;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_POINT = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [2:0] TOK_HEADER = 3'd1;
    localparam logic [2:0] TOK_LAT    = 3'd4;
    localparam logic [2:0] TOK_SPLIT  = 3'd5;
    localparam logic [2:0] TOK_LON    = 3'd6;
    localparam logic [2:0] TOK_MAX    = 3'd7;

    typedef enum logic [1:0] {
        ST_POS_FOUND     = 2'd0,
        ST_NOT_RMC       = 2'd1,
        ST_FIELD_MISSING = 2'd2
    } t_status;

    typedef struct packed {
        logic       clear;
        logic       feed;
        logic [7:0] ch;
    } t_num_ctrl;

    typedef struct packed {
        t_status                 status;
        logic signed [OUT_W-1:0] lat;
        logic signed [OUT_W-1:0] lon;
    } t_line_res;

    // characters of the "$GPRMC" header
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'd36;
            3'd1:    c = 8'd71;
            3'd2:    c = 8'd80;
            3'd3:    c = 8'd82;
            3'd4:    c = 8'd77;
            3'd5:    c = 8'd67;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [POW_W-1:0] pow10(input logic [2:0] n);
        logic [POW_W-1:0] p;
        case (n)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

[hw/rtl/nrpe_number.sv]
// decimal number accumulator and fixed-point scaling of one token
// depends on nrpe_pkg and the assertion macro header
`include "nmea_rmc_position_extractor_core_assert.svh"

module nrpe_number #(
    parameter int FRAC_DIGITS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  nrpe_pkg::t_num_ctrl                  i_ctrl,
    output logic signed [nrpe_pkg::OUT_W-1:0]    o_result
);

    localparam logic [2:0] FRAC = 3'(FRAC_DIGITS);

    logic [nrpe_pkg::VAL_W-1:0] r_val, n_val, b_val;
    logic                       r_neg, n_neg, b_neg;
    logic                       r_stopped, n_stopped, b_stopped;
    logic                       r_point, n_point, b_point;
    logic                       r_started, n_started, b_started;
    logic [2:0]                 r_fc, n_fc, b_fc;

    logic [nrpe_pkg::VAL_W+3:0]  w_v10;
    logic                        w_digit;
    logic [nrpe_pkg::PROD_W-1:0] w_prod;
    logic [nrpe_pkg::VAL_W-1:0]  w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val     <= '0;
            r_neg     <= 1'b0;
            r_stopped <= 1'b0;
            r_point   <= 1'b0;
            r_started <= 1'b0;
            r_fc      <= '0;
        end else begin
            r_val     <= n_val;
            r_neg     <= n_neg;
            r_stopped <= n_stopped;
            r_point   <= n_point;
            r_started <= n_started;
            r_fc      <= n_fc;
        end
    end

    always_comb begin
        // a token start clears first, then its first character is fed
        if (i_ctrl.clear) begin
            b_val     = '0;
            b_neg     = 1'b0;
            b_stopped = 1'b0;
            b_point   = 1'b0;
            b_started = 1'b0;
            b_fc      = '0;
        end else begin
            b_val     = r_val;
            b_neg     = r_neg;
            b_stopped = r_stopped;
            b_point   = r_point;
            b_started = r_started;
            b_fc      = r_fc;
        end
        n_val     = b_val;
        n_neg     = b_neg;
        n_stopped = b_stopped;
        n_point   = b_point;
        n_started = b_started;
        n_fc      = b_fc;

        w_digit = (i_ctrl.ch >= nrpe_pkg::CH_ZERO) && (i_ctrl.ch <= nrpe_pkg::CH_NINE);
        w_v10   = ({4'b0, b_val} << 3) + ({4'b0, b_val} << 1) +
                  {30'b0, i_ctrl.ch[3:0]};

        if (i_ctrl.feed && !b_stopped) begin
            priority if (!b_started && nrpe_pkg::is_blank(i_ctrl.ch)) begin
                n_started = 1'b0;
            end else if (!b_started && (i_ctrl.ch == nrpe_pkg::CH_PLUS ||
                                        i_ctrl.ch == nrpe_pkg::CH_MINUS)) begin
                n_neg     = (i_ctrl.ch == nrpe_pkg::CH_MINUS);
                n_started = 1'b1;
            end else if (w_digit) begin
                n_started = 1'b1;
                // digits past the kept fraction are dropped
                if (!(b_point && b_fc >= FRAC)) begin
                    n_val = (w_v10 > {4'b0, nrpe_pkg::SAT_MAG}) ? nrpe_pkg::SAT_MAG
                                                                 : w_v10[nrpe_pkg::VAL_W-1:0];
                    if (b_point) begin
                        n_fc = b_fc + 3'd1;
                    end
                end
            end else if (i_ctrl.ch == nrpe_pkg::CH_POINT && !b_point) begin
                n_started = 1'b1;
                n_point   = 1'b1;
            end else begin
                n_started = 1'b1;
                n_stopped = 1'b1;
            end
        end
    end

    // scale to the fixed point; saturating once at the end matches stepwise saturation
    assign w_prod = nrpe_pkg::PROD_W'(r_val) *
                    nrpe_pkg::PROD_W'(nrpe_pkg::pow10(FRAC - r_fc));
    assign w_mag  = (w_prod > nrpe_pkg::PROD_W'(nrpe_pkg::SAT_MAG)) ? nrpe_pkg::SAT_MAG
                                                                 : w_prod[nrpe_pkg::VAL_W-1:0];
    assign o_result = r_neg ? (31'd0 - {1'b0, w_mag}) : {1'b0, w_mag};

    `NRPE_ASSERT(a_frac_bound, i_clk, i_rst_n, r_fc <= FRAC)
    `NRPE_ASSERT(a_val_bound, i_clk, i_rst_n, r_val <= nrpe_pkg::SAT_MAG)
    `NRPE_ASSERT_IMPL(a_started, i_clk, i_rst_n, r_stopped || r_point, r_started)

endmodule

[hw/rtl/nrpe_line.sv]
// line tokenizer: header match, token counting, line length and result build
// depends on nrpe_pkg; drives the number accumulator
module nrpe_line #(
    parameter int LINE_LIMIT = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic [7:0]                        i_byte,
    input  logic signed [nrpe_pkg::OUT_W-1:0] i_num_result,
    output nrpe_pkg::t_num_ctrl               o_num_ctrl,
    output nrpe_pkg::t_line_res               o_res
);

    localparam int              LEN_W    = $clog2(LINE_LIMIT);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_LIMIT - 1);

    logic [2:0]                        r_hdr_pos, n_hdr_pos;
    logic                              r_hdr_ok, n_hdr_ok;
    logic [2:0]                        r_tok_cnt, n_tok_cnt;
    logic                              r_in_tok, n_in_tok;
    logic signed [nrpe_pkg::OUT_W-1:0] r_held_lat, n_held_lat;
    logic [LEN_W-1:0]                  r_len, n_len;
    logic [2:0]                        w_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos  <= '0;
            r_hdr_ok   <= 1'b1;
            r_tok_cnt  <= '0;
            r_in_tok   <= 1'b0;
            r_held_lat <= '0;
            r_len      <= '0;
        end else begin
            r_hdr_pos  <= n_hdr_pos;
            r_hdr_ok   <= n_hdr_ok;
            r_tok_cnt  <= n_tok_cnt;
            r_in_tok   <= n_in_tok;
            r_held_lat <= n_held_lat;
            r_len      <= n_len;
        end
    end

    always_comb begin
        n_hdr_pos        = r_hdr_pos;
        n_hdr_ok         = r_hdr_ok;
        n_tok_cnt        = r_tok_cnt;
        n_in_tok         = r_in_tok;
        n_held_lat       = r_held_lat;
        n_len            = r_len;
        w_tok            = r_tok_cnt;
        o_num_ctrl.clear = 1'b0;
        o_num_ctrl.feed  = 1'b0;
        o_num_ctrl.ch    = i_byte;

        if (i_adv) begin
            priority if (i_byte == nrpe_pkg::CH_NL) begin
                n_hdr_pos        = '0;
                n_hdr_ok         = 1'b1;
                n_tok_cnt        = '0;
                n_in_tok         = 1'b0;
                n_held_lat       = '0;
                n_len            = '0;
                o_num_ctrl.clear = 1'b1;
            end else if (i_byte != nrpe_pkg::CH_NUL && r_len < LEN_LAST) begin
                n_len = r_len + 1'b1;
                if (i_byte == nrpe_pkg::CH_COMMA) begin
                    n_in_tok = 1'b0;
                end else begin
                    if (!r_in_tok) begin
                        n_in_tok = 1'b1;
                        if (r_tok_cnt < nrpe_pkg::TOK_MAX) begin
                            w_tok = r_tok_cnt + 3'd1;
                            // latitude is frozen when the token after it begins
                            if (w_tok == nrpe_pkg::TOK_SPLIT) begin
                                n_held_lat = i_num_result;
                            end
                            if (w_tok == nrpe_pkg::TOK_LAT || w_tok == nrpe_pkg::TOK_LON) begin
                                o_num_ctrl.clear = 1'b1;
                            end
                        end
                    end
                    n_tok_cnt = w_tok;
                    if (w_tok == nrpe_pkg::TOK_HEADER) begin
                        if (r_hdr_pos < 3'(nrpe_pkg::HDR_LEN) &&
                            i_byte == nrpe_pkg::hdr_char(r_hdr_pos)) begin
                            n_hdr_pos = r_hdr_pos + 3'd1;
                        end else begin
                            n_hdr_ok = 1'b0;
                        end
                    end else if (w_tok == nrpe_pkg::TOK_LAT || w_tok == nrpe_pkg::TOK_LON) begin
                        o_num_ctrl.feed = 1'b1;
                    end
                end
            end else begin
                n_len = r_len;
            end
        end
    end

    always_comb begin
        o_res.lat = '0;
        o_res.lon = '0;
        if (r_tok_cnt >= 3'd1 && r_hdr_ok && r_hdr_pos == 3'(nrpe_pkg::HDR_LEN)) begin
            if (r_tok_cnt >= nrpe_pkg::TOK_LON) begin
                o_res.status = nrpe_pkg::ST_POS_FOUND;
                o_res.lat    = r_held_lat;
                o_res.lon    = i_num_result;
            end else begin
                o_res.status = nrpe_pkg::ST_FIELD_MISSING;
            end
        end else begin
            o_res.status = nrpe_pkg::ST_NOT_RMC;
        end
    end

endmodule

[hw/rtl/nmea_rmc_position_extractor_core.sv]
// top level of the rmc position extractor: input register, tokenizer, number unit
// and result register; depends on nrpe_pkg, nrpe_line, nrpe_number
//
//  channel   dir  beat contents
//  s_axis    in   tdata[7:0] rx_byte
//  m_axis    out  tdata[1:0] line_status, [32:2] latitude_scaled, [63:33] longitude_scaled
//
// one byte per cycle while no newline waits on the result register; a byte is held in the input
// register and a newline puts its result from there into the output register
// the critical path is the 30x20 scaling multiply in the number unit
// synchronous active-low reset returns all line state to the start of a line
// a stalled result blocks only a following newline; other bytes keep flowing
`include "nmea_rmc_position_extractor_core_assert.svh"

module nmea_rmc_position_extractor_core #(
    parameter int FRAC_DIGITS = 4,
    parameter int LINE_LIMIT  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata    // [1:0] line_status, [32:2] lat, [63:33] lon
);

    logic                              r_in_valid;
    logic [7:0]                        r_in_byte;
    logic                              w_adv;
    logic                              w_nl;

    logic                              r_out_valid;
    nrpe_pkg::t_status                 r_out_status;
    logic signed [nrpe_pkg::OUT_W-1:0] r_out_lat;
    logic signed [nrpe_pkg::OUT_W-1:0] r_out_lon;

    nrpe_pkg::t_num_ctrl               w_num_ctrl;
    nrpe_pkg::t_line_res               w_res;
    logic signed [nrpe_pkg::OUT_W-1:0] w_num_result;

    assign w_nl       = (r_in_byte == nrpe_pkg::CH_NL);
    // a newline waits only while the result register is still held
    assign w_adv      = r_in_valid && (!w_nl || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_nl) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_nl) begin
            r_out_status <= w_res.status;
            r_out_lat    <= w_res.lat;
            r_out_lon    <= w_res.lon;
        end
    end

    nrpe_line #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_line (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_byte       (r_in_byte),
        .i_num_result (w_num_result),
        .o_num_ctrl   (w_num_ctrl),
        .o_res        (w_res)
    );

    nrpe_number #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_number (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_num_ctrl),
        .o_result (w_num_result)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_lon, r_out_lat, r_out_status};

    `NRPE_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid && $stable(r_in_byte))
    `NRPE_ASSERT_NEXT(a_result_load, i_clk, i_rst_n, w_adv && w_nl, r_out_valid)
    `NRPE_ASSERT_IMPL(a_zero_fields, i_clk, i_rst_n, r_out_valid && r_out_status != nrpe_pkg::ST_POS_FOUND, r_out_lat == '0 && r_out_lon == '0)

endmodule

[dv/nmea_rmc_result_checker.sv]
// checker of the rmc position extractor: watches both stream channels, predicts the line
// results from the accepted bytes and compares every result beat; depends on nrpe_pkg
module nmea_rmc_result_checker #(
    parameter int FRAC_DIGITS = 4,
    parameter int LINE_LIMIT  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,   // [1:0] line_status, [32:2] lat, [63:33] lon
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import nrpe_pkg::*;

    localparam logic [47:0] RMC_TAG  = "$GPRMC";
    localparam logic [63:0] MAG_LIMIT = 64'd999999999;

    t_line_res expected_lines[$];
    int        failures = 0;
    int        results  = 0;

    // parser state, cleared at every newline
    logic [2:0]               tag_pos;
    logic                     tag_ok;
    logic [2:0]               tok_cnt;
    logic                     in_tok;
    logic [VAL_W-1:0]         num_val;
    logic                     num_neg;
    logic                     num_stop;
    logic                     num_pt;
    logic                     num_begun;
    logic [2:0]               frac_cnt;
    logic signed [OUT_W-1:0]  lat_hold;
    logic [$clog2(LINE_LIMIT)-1:0] line_len;

    task automatic clear_number();
        num_val   = '0;
        num_neg   = 1'b0;
        num_stop  = 1'b0;
        num_pt    = 1'b0;
        num_begun = 1'b0;
        frac_cnt  = '0;
    endtask

    task automatic clear_line();
        tag_pos  = '0;
        tag_ok   = 1'b1;
        tok_cnt  = '0;
        in_tok   = 1'b0;
        lat_hold = '0;
        line_len = '0;
        clear_number();
    endtask

    // value of the number read so far, times ten to FRAC_DIGITS, saturated
    function automatic logic signed [OUT_W-1:0] scaled_number();
        logic [63:0]             m;
        logic signed [OUT_W-1:0] mag;
        m = 64'(num_val);
        for (int k = int'(frac_cnt); k < FRAC_DIGITS; k++) begin
            m = m * 10;
            if (m > MAG_LIMIT) m = MAG_LIMIT;
        end
        mag = m[OUT_W-1:0];
        return num_neg ? -mag : mag;
    endfunction

    function automatic logic is_space_char(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    task automatic parse_char(input logic [7:0] c);
        t_line_res   r;
        logic [63:0] v;
        if (c == CH_NL) begin
            r.lat = '0;
            r.lon = '0;
            if (tok_cnt >= TOK_HEADER && tag_ok && tag_pos == 3'(HDR_LEN)) begin
                if (tok_cnt >= TOK_LON) begin
                    r.status = ST_POS_FOUND;
                    r.lat    = lat_hold;
                    r.lon    = scaled_number();
                end else begin
                    r.status = ST_FIELD_MISSING;
                end
            end else begin
                r.status = ST_NOT_RMC;
            end
            expected_lines.push_back(r);
            clear_line();
        end else if (c != CH_NUL && int'(line_len) < LINE_LIMIT - 1) begin
            line_len = line_len + 1'b1;
            if (c == CH_COMMA) begin
                in_tok = 1'b0;
            end else begin
                if (!in_tok) begin
                    in_tok = 1'b1;
                    if (tok_cnt < TOK_MAX) begin
                        tok_cnt = tok_cnt + 1'b1;
                        if (tok_cnt == TOK_SPLIT) lat_hold = scaled_number();
                        if (tok_cnt == TOK_LAT || tok_cnt == TOK_LON) clear_number();
                    end
                end
                if (tok_cnt == TOK_HEADER) begin
                    if (tag_pos < 3'(HDR_LEN) && c == RMC_TAG[47 - 8*tag_pos -: 8])
                        tag_pos = tag_pos + 1'b1;
                    else
                        tag_ok = 1'b0;
                end else if ((tok_cnt == TOK_LAT || tok_cnt == TOK_LON) && !num_stop) begin
                    // atof-like scan: blanks and a sign only before the first other char
                    if (!num_begun && is_space_char(c)) begin
                        // skipped
                    end else if (!num_begun && (c == CH_PLUS || c == CH_MINUS)) begin
                        num_neg   = (c == CH_MINUS);
                        num_begun = 1'b1;
                    end else begin
                        num_begun = 1'b1;
                        if (c >= CH_ZERO && c <= CH_NINE) begin
                            if (!(num_pt && int'(frac_cnt) >= FRAC_DIGITS)) begin
                                v = 64'(num_val) * 10 + 64'(c - CH_ZERO);
                                num_val = (v > MAG_LIMIT) ? SAT_MAG : v[VAL_W-1:0];
                                if (num_pt) frac_cnt = frac_cnt + 1'b1;
                            end
                        end else if (c == CH_POINT && !num_pt) begin
                            num_pt = 1'b1;
                        end else begin
                            num_stop = 1'b1;
                        end
                    end
                end
            end
        end
    endtask

    task automatic compare_result(input logic [63:0] beat);
        t_line_res               want;
        t_status                 got_status;
        logic signed [OUT_W-1:0] got_lat;
        logic signed [OUT_W-1:0] got_lon;
        got_status = t_status'(beat[1:0]);
        got_lat    = beat[32:2];
        got_lon    = beat[63:33];
        results++;
        if (expected_lines.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("[%0t] unexpected result beat: status %0d lat %0d lon %0d",
                         $realtime, got_status, got_lat, got_lon);
        end else begin
            want = expected_lines.pop_front();
            if (got_status !== want.status || got_lat !== want.lat || got_lon !== want.lon)
            begin
                failures++;
                if (failures <= 10)
                    $display("[%0t] result %0d mismatch: status %0d/%0d lat %0d/%0d lon %0d/%0d %s",
                             $realtime, results, want.status, got_status, want.lat, got_lat,
                             want.lon, got_lon, "(expected/actual)");
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line();
            expected_lines.delete();
        end else begin
            // a result beat always belongs to an earlier newline
            if (i_m_tvalid && i_m_tready) compare_result(i_m_tdata);
            if (i_s_tvalid && i_s_tready) parse_char(i_s_tdata);
        end
        o_pending    <= expected_lines.size();
        o_fail_count <= failures;
        o_results    <= results;
    end

endmodule

[dv/testbench.sv]
// top of the rmc position extractor testbench: clock, reset, byte stimulus and verdict
// depends on nrpe_pkg, nmea_rmc_position_extractor_core and nmea_rmc_result_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nrpe_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        rx_valid = 1'b0;
    logic [7:0]  rx_data  = 8'd0;
    logic        res_ready = 1'b0;
    logic        rx_ready;
    logic        res_valid;
    logic [63:0] res_data;

    int fail_count;
    int pending;
    int results;

    int src_idle_pct = 26;
    int dst_idle_pct = 50;
    int bytes_sent   = 0;
    int lines_sent   = 0;

    logic [7:0] line_bytes[$];

    nmea_rmc_position_extractor_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (rx_valid),
        .o_s_tready (rx_ready),
        .i_s_tdata  (rx_data),
        .o_m_tvalid (res_valid),
        .i_m_tready (res_ready),
        .o_m_tdata  (res_data)
    );

    nmea_rmc_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (rx_valid),
        .i_s_tready   (rx_ready),
        .i_s_tdata    (rx_data),
        .i_m_tvalid   (res_valid),
        .i_m_tready   (res_ready),
        .i_m_tdata    (res_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        res_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // ends the run when nothing moves on either channel for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((rx_valid && rx_ready) || (res_valid && res_ready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] any_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CH_NL);
        return c;
    endfunction

    function automatic logic [7:0] digit_char();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(8'(s[i]));
    endtask

    task automatic send_byte(input logic [7:0] c);
        int gaps;
        gaps = 0;
        while (gaps < 30 && $urandom_range(99) < src_idle_pct) gaps++;
        if (gaps > 0) begin
            rx_valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_data  <= c;
        @(posedge clk);
        while (!rx_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_line();
        while (line_bytes.size() > 0) send_byte(line_bytes.pop_front());
        lines_sent++;
    endtask

    // sender holds off until every predicted result has been seen
    task automatic drain();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic add_number();
        string trail;
        int    n;
        trail = "eE.x+-*N \r";
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(4))
                    0:       line_bytes.push_back(CH_SPACE);
                    1:       line_bytes.push_back(CH_TAB);
                    2:       line_bytes.push_back(CH_VT);
                    3:       line_bytes.push_back(CH_FF);
                    default: line_bytes.push_back(CH_CR);
                endcase
            end
        end
        case ($urandom_range(3))
            0:       line_bytes.push_back(CH_MINUS);
            1:       line_bytes.push_back(CH_PLUS);
            default: ;
        endcase
        n = ($urandom_range(5) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
        repeat (n) line_bytes.push_back(digit_char());
        if ($urandom_range(4) != 0) begin
            line_bytes.push_back(CH_POINT);
            repeat ($urandom_range(0, 8)) line_bytes.push_back(digit_char());
        end
        if ($urandom_range(3) == 0) line_bytes.push_back(8'(trail[$urandom_range(trail.len()-1)]));
        if ($urandom_range(19) == 0) line_bytes.push_back(any_char());
    endtask

    // rmc-shaped line with the given number of fields, optionally with a damaged header
    task automatic add_rmc(input int fields, input bit bad_header);
        string tag;
        tag = "$GPRMC";
        if (bad_header) begin
            case ($urandom_range(3))
                0:       tag[$urandom_range(5)] = byte'(any_char());
                1:       tag = {tag, "X"};
                2:       tag = "$GPRM";
                default: tag = "$GPGGA";
            endcase
        end
        if ($urandom_range(9) == 0) line_bytes.push_back(CH_COMMA);
        for (int k = 1; k <= fields; k++) begin
            if (k > 1) begin
                line_bytes.push_back(CH_COMMA);
                if ($urandom_range(9) == 0) line_bytes.push_back(CH_COMMA);
            end
            case (k)
                1: add_text(tag);
                2: begin
                    repeat (6) line_bytes.push_back(digit_char());
                    add_text(".00");
                end
                3: add_text($urandom_range(1) ? "A" : "V");
                4, 6: add_number();
                5: add_text($urandom_range(1) ? "N" : "S");
                7: add_text($urandom_range(1) ? "E" : "W");
                default: repeat ($urandom_range(1, 5)) line_bytes.push_back(digit_char());
            endcase
        end
        if ($urandom_range(1)) begin
            add_text("*");
            repeat (2) line_bytes.push_back(digit_char());
        end
        if ($urandom_range(9) < 7) line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_NL);
    endtask

    task automatic add_random_line();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) begin
            add_rmc($urandom_range(6, 12), 1'b0);
        end else if (pick < 80) begin
            if ($urandom_range(1)) add_rmc($urandom_range(1, 5), 1'b0);
            else add_rmc($urandom_range(1, 9), 1'b1);
        end else if (pick < 97) begin
            if ($urandom_range(1)) add_text("$GPRMC,");
            repeat ($urandom_range(0, 40)) line_bytes.push_back(any_char());
            line_bytes.push_back(CH_NL);
        end else begin
            add_text("$GPRMC,");
            repeat ($urandom_range(240, 300)) line_bytes.push_back(digit_char());
            add_text(",A,1.5,N,-2.5,E\n");
        end
    endtask

    initial begin
        int phase_bytes;
        int phase_lines;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed lines
        add_text("\n");
        add_text(",,,\n");
        add_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n");
        add_text("$GPRMC,1,A,4807\n");
        add_text("$GPRMC\n");
        add_text("$GPRMC,t,A,5,N\n");
        add_text("$GPRMCX,1,A,1,N,2\n");
        add_text("$GPGGA,1,A,1,N,2\n");
        add_text("$GPRMC,,,1,,A,,,-12.5,N,+7.25\n");
        add_text(",$GPRMC,t,A,1,N,2\n");
        add_text("$GPRMC,x,A,99999999999.9,N,-99999999999,E\n");
        add_text("$GPRMC,t,A,1.23456789,N,-0.00001,E\n");
        add_text("$GPRMC,t,A,abc,N,inf,E\n");
        add_text("$GPRMC,t,A,1e5,N,0x1F,E\n");
        add_text("$GPRMC,t,A,  \t-3.5,N, \r+.5\r,E\n");
        add_text("$GPRMC,t,A,--5,N,1.2.3,E\n");
        add_text("$GPRMC,t,A,+-1,N,. .5,E\n");
        add_text("$GPRMC,t,A,1,N,2,E,3,4,5,6,7,8,9\n");
        add_text("$GP");
        line_bytes.push_back(CH_NUL);
        add_text("RMC,t,A,1");
        line_bytes.push_back(CH_NUL);
        add_text("7,N,2\n");
        add_text("$GPRMC,t,A,");
        line_bytes.push_back(8'd255);
        add_text(",N,");
        line_bytes.push_back(8'd128);
        add_text("9\n");
        add_text("$GPRMC,");
        repeat (260) add_text("a");
        add_text(",A,1,N,2\n");
        while (line_bytes.size() > 0) begin
            send_byte(line_bytes[0]);
            if (line_bytes.pop_front() == CH_NL) lines_sent++;
        end
        drain();

        // random lines under three idle profiles
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 26; dst_idle_pct = 50; end
                1:       begin src_idle_pct = 50; dst_idle_pct = 26; end
                default: begin src_idle_pct = 0;  dst_idle_pct = 0;  end
            endcase
            phase_bytes = 0;
            phase_lines = 0;
            while (phase_bytes < 100 || phase_lines < 4) begin
                add_random_line();
                phase_bytes += line_bytes.size();
                send_line();
                phase_lines++;
                if (phase_lines == 2) drain();
            end
            drain();
        end

        repeat (8) @(posedge clk);
        $display("sent %0d bytes in %0d lines, checked %0d line results", bytes_sent,
                 lines_sent, results);
        $display("lines covered: rmc fixes, short and foreign lines, noise, overlong lines");
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/nrpe_pkg.sv
hw/rtl/nrpe_number.sv
hw/rtl/nrpe_line.sv
hw/rtl/nmea_rmc_position_extractor_core.sv
dv/nmea_rmc_result_checker.sv
dv/testbench.sv
